// File: hdl/height_to_normal_map_unit_defines.svh
// Assertion macros for the height to normal map unit.
// Used by the top level only; depends on nothing else.
`ifndef HEIGHT_TO_NORMAL_MAP_UNIT_DEFINES_SVH
`define HEIGHT_TO_NORMAL_MAP_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define HNM_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("hnm assertion failed");
`define HNM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("hnm assertion failed");
`else
`define HNM_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define HNM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: hdl/hnm_pkg.sv
// Shared types, constants and helpers of the height to normal map unit.
// No dependencies.
package hnm_pkg;
    localparam int DEF_MAX_WIDTH        = 2048;
    localparam int DEF_SCALE_FRAC_BITS  = 8;
    localparam int DEF_NORMAL_FRAC_BITS = 15;
    localparam int FIFO_DEPTH           = 4;
    localparam int DX_W                 = 11;  // |gradient| <= 1020
    localparam int SCALE_W              = 16;
    localparam int IMG_W_W              = 12;
    localparam int IMG_H_W              = 16;
    localparam int CFG_IDX_W            = 8;

    localparam logic [IMG_W_W-1:0] RST_IMAGE_WIDTH  = 12'd512;
    localparam logic [IMG_H_W-1:0] RST_IMAGE_HEIGHT = 16'd512;
    localparam logic [SCALE_W-1:0] RST_SCALE        = 16'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 8'd0,
        CFG_IMAGE_HEIGHT = 8'd1,
        CFG_SCALE_X      = 8'd2,
        CFG_SCALE_Y      = 8'd3
    } cfg_idx_t;

    typedef enum logic {
        OP_PUSH  = 1'b0,
        OP_DRAIN = 1'b1
    } op_t;

    typedef enum logic {
        FE_IDLE,
        FE_UPDATE
    } fe_state_t;

    typedef enum logic [3:0] {
        BE_IDLE,
        BE_SCALE,
        BE_MAG,
        BE_SQX,
        BE_SUM,
        BE_ROOT,
        BE_DINIT,
        BE_DIV,
        BE_ENC,
        BE_DONE
    } be_state_t;

    typedef struct packed {
        logic signed [DX_W-1:0] dx;
        logic signed [DX_W-1:0] dy;
        logic [7:0]             alpha;
        logic                   last;
    } job_t;

    function automatic logic signed [DX_W-1:0] px_ext(input logic [7:0] v);
        px_ext = $signed({{(DX_W-8){1'b0}}, v});
    endfunction
endpackage

// File: hdl/hnm_fifo.sv
// Short job queue between the window front end and the normal back end.
// Depends on hnm_pkg.
module hnm_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  hnm_pkg::job_t din,
    output logic          full,
    input  logic          pop,
    output hnm_pkg::job_t dout,
    output logic          empty
);
    import hnm_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    job_t               mem_reg [DEPTH];
    logic [PW-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]        count_reg;

    assign full  = (count_reg == (PW+1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push && !full) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop && !empty) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (PW+1)'(push && !full) - (PW+1)'(pop && !empty);
        end
    end
endmodule

// File: hdl/hnm_front.sv
// Front end: takes words, runs line stores, 3x3 window and raster counters,
// and queues gradient jobs. Depends on hnm_pkg.
module hnm_front #(
    parameter int MAX_WIDTH = hnm_pkg::DEF_MAX_WIDTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_op,
    input  logic [7:0]                   s_height,
    input  logic [hnm_pkg::IMG_W_W-1:0]  image_width,
    input  logic [hnm_pkg::IMG_H_W-1:0]  image_height,
    output logic                         job_push,
    output hnm_pkg::job_t                job,
    input  logic                         fifo_full
);
    import hnm_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = AW + 1;

    fe_state_t         state_reg, state_next;
    logic [7:0]        upper_mem [MAX_WIDTH];
    logic [7:0]        lower_mem [MAX_WIDTH];
    logic [7:0]        up_q_reg, lo_q_reg;
    logic [7:0]        win_reg  [3][3];
    logic [7:0]        nw       [3][3];
    logic [AW-1:0]     in_col_reg, out_col_reg;
    logic [15:0]       in_row_reg, out_row_reg;
    logic [7:0]        sample_reg;
    logic [CW-1:0]     eff_w;
    logic [15:0]       eff_h;
    logic              accept, ignore, primed, commit;
    logic              in_wrap, out_wrap, last;
    logic              left, right, top, bottom;
    logic signed [DX_W-1:0] ctr, x0, x1, y0, y1, xy0, xy1, xy2, xy3;

    always_comb begin
        if (image_width == '0) begin
            eff_w = CW'(1);
        end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
            eff_w = CW'(MAX_WIDTH);
        end else begin
            eff_w = CW'(image_width);
        end
        eff_h = (image_height == '0) ? 16'd1 : image_height;
    end

    assign s_ready = (state_reg == FE_IDLE);
    assign accept  = s_valid && s_ready;
    // a drain before the frame is fully in is dropped
    assign ignore  = (s_op == OP_DRAIN) && (in_row_reg < eff_h);

    assign primed = (in_row_reg >= 16'd2) || ((in_row_reg == 16'd1) && (in_col_reg != '0));
    assign commit = (state_reg == FE_UPDATE) && (!primed || !fifo_full);

    assign in_wrap  = ({1'b0, in_col_reg} + CW'(1)) >= eff_w;
    assign out_wrap = ({1'b0, out_col_reg} + CW'(1)) >= eff_w;
    assign left     = (out_col_reg != '0);
    assign right    = !out_wrap;
    assign top      = (out_row_reg != '0);
    assign bottom   = (17'(out_row_reg) + 17'd1) < 17'(eff_h);
    assign last     = !bottom && out_wrap;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            nw[r][0] = win_reg[r][1];
            nw[r][1] = win_reg[r][2];
        end
        nw[0][2] = up_q_reg;
        nw[1][2] = lo_q_reg;
        nw[2][2] = sample_reg;
    end

    always_comb begin
        ctr = px_ext(nw[1][1]);
        x0  = left  ? px_ext(nw[1][0]) : ctr;
        x1  = right ? px_ext(nw[1][2]) : ctr;
        y0  = top   ? px_ext(nw[0][1]) : ctr;
        y1  = bottom ? px_ext(nw[2][1]) : ctr;
        xy0 = (left && top)     ? px_ext(nw[0][0]) : ctr;
        xy1 = (right && top)    ? px_ext(nw[0][2]) : ctr;
        xy2 = (left && bottom)  ? px_ext(nw[2][0]) : ctr;
        xy3 = (right && bottom) ? px_ext(nw[2][2]) : ctr;
        job.dx    = ((x0 - x1) <<< 1) + (xy0 - xy1) + (xy2 - xy3);
        job.dy    = ((y0 - y1) <<< 1) + (xy0 - xy2) + (xy1 - xy3);
        job.alpha = nw[1][1];
        job.last  = last;
    end

    assign job_push = commit && primed;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FE_IDLE:   if (accept && !ignore) state_next = FE_UPDATE;
            FE_UPDATE: if (commit) state_next = FE_IDLE;
            default:   state_next = FE_IDLE;
        endcase
    end

    // line stores: read on accept, write back on commit
    always_ff @(posedge aclk) begin
        if (accept) begin
            up_q_reg <= upper_mem[in_col_reg];
            lo_q_reg <= lower_mem[in_col_reg];
        end
        if (commit) begin
            upper_mem[in_col_reg] <= lo_q_reg;
            lower_mem[in_col_reg] <= sample_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_reg <= (s_op == OP_DRAIN) ? 8'd0 : s_height;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FE_IDLE;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    win_reg[r][c] <= '0;
                end
            end
        end else begin
            state_reg <= state_next;
            if (commit) begin
                win_reg <= nw;
                if (primed && last) begin
                    in_col_reg  <= '0;
                    in_row_reg  <= '0;
                    out_col_reg <= '0;
                    out_row_reg <= '0;
                end else begin
                    if (in_wrap) begin
                        in_col_reg <= '0;
                        if (in_row_reg != 16'hFFFF) in_row_reg <= in_row_reg + 16'd1;
                    end else begin
                        in_col_reg <= in_col_reg + 1'b1;
                    end
                    if (primed) begin
                        if (out_wrap) begin
                            out_col_reg <= '0;
                            if (out_row_reg != 16'hFFFF) out_row_reg <= out_row_reg + 16'd1;
                        end else begin
                            out_col_reg <= out_col_reg + 1'b1;
                        end
                    end
                end
            end
        end
    end
endmodule

// File: hdl/hnm_back.sv
// Back end: scales gradients, takes the vector length by a bit-pair square
// root, divides each component by a restoring divider and encodes to 8 bits.
// Depends on hnm_pkg.
module hnm_back #(
    parameter int SCALE_FRAC_BITS  = hnm_pkg::DEF_SCALE_FRAC_BITS,
    parameter int NORMAL_FRAC_BITS = hnm_pkg::DEF_NORMAL_FRAC_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [hnm_pkg::SCALE_W-1:0]  scale_x,
    input  logic [hnm_pkg::SCALE_W-1:0]  scale_y,
    input  hnm_pkg::job_t                job,
    input  logic                         fifo_empty,
    output logic                         job_pop,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [31:0]                  m_data,
    output logic                         m_last
);
    import hnm_pkg::*;

    localparam int G_W    = DX_W + SCALE_W + 1;
    localparam int V_W    = 2 * G_W + 2;
    localparam int ROOT_W = V_W / 2;
    localparam int Q      = NORMAL_FRAC_BITS + 1;
    localparam int CNT_MAX = (ROOT_W > Q) ? ROOT_W : Q;
    localparam int CNT_W  = $clog2(CNT_MAX + 1);

    be_state_t              state_reg, state_next;
    logic signed [G_W-1:0]  gx_reg, gy_reg;
    logic [G_W-1:0]         magx_reg, magy_reg;
    logic [V_W-1:0]         acc_reg;
    logic [ROOT_W:0]        rem_s_reg;
    logic [ROOT_W-1:0]      root_reg;
    logic [ROOT_W-1:0]      drem_reg;
    logic [Q-1:0]           dbits_reg, q_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [1:0]             comp_reg;
    logic [7:0]             chan_reg [3];
    logic [7:0]             alpha_reg;
    logic                   last_reg;
    logic                   out_valid_reg;
    logic [7:0]             out_r_reg, out_g_reg, out_b_reg, out_a_reg;
    logic                   out_last_reg;
    logic                   load_out, root_done, div_done;

    logic [ROOT_W+2:0]      s_cand, s_trial;
    logic [ROOT_W:0]        d_cand;
    logic [G_W-1:0]         dmag;
    logic                   dneg;
    logic [Q:0]             biased;
    logic [Q+8:0]           prod;
    logic [V_W-1:0]         one_sq;

    assign one_sq = V_W'(1) << (2 * SCALE_FRAC_BITS);

    // sqrt step: bring down two bits, try (root<<2)|1
    assign s_cand  = {rem_s_reg, acc_reg[V_W-1:V_W-2]};
    assign s_trial = {1'b0, root_reg, 2'b01};
    // divide step: remainder always below len
    assign d_cand  = {drem_reg, dbits_reg[Q-1]};

    always_comb begin
        unique case (comp_reg)
            2'd0:    begin dmag = magx_reg; dneg = gx_reg[G_W-1]; end
            2'd1:    begin dmag = magy_reg; dneg = gy_reg[G_W-1]; end
            default: begin dmag = G_W'(1) << SCALE_FRAC_BITS; dneg = 1'b0; end
        endcase
    end

    assign biased = dneg ? ((Q+1)'(1) << NORMAL_FRAC_BITS) - (Q+1)'(q_reg)
                         : ((Q+1)'(1) << NORMAL_FRAC_BITS) + (Q+1)'(q_reg);
    assign prod   = {biased, 8'd0} - (Q+9)'(biased);

    assign root_done = (cnt_reg == CNT_W'(ROOT_W - 1));
    assign div_done  = (cnt_reg == CNT_W'(Q - 1));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BE_IDLE:  if (!fifo_empty) state_next = BE_SCALE;
            BE_SCALE: state_next = BE_MAG;
            BE_MAG:   state_next = BE_SQX;
            BE_SQX:   state_next = BE_SUM;
            BE_SUM:   state_next = BE_ROOT;
            BE_ROOT:  if (root_done) state_next = BE_DINIT;
            BE_DINIT: state_next = BE_DIV;
            BE_DIV:   if (div_done) state_next = BE_ENC;
            BE_ENC:   state_next = (comp_reg == 2'd2) ? BE_DONE : BE_DINIT;
            BE_DONE:  if (!out_valid_reg || m_ready) state_next = BE_IDLE;
            default:  state_next = BE_IDLE;
        endcase
    end

    always_comb begin
        job_pop  = (state_reg == BE_IDLE) && !fifo_empty;
        load_out = (state_reg == BE_DONE) && (!out_valid_reg || m_ready);
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            BE_IDLE: begin
                if (!fifo_empty) begin
                    gx_reg    <= G_W'(job.dx);
                    gy_reg    <= G_W'(job.dy);
                    alpha_reg <= job.alpha;
                    last_reg  <= job.last;
                end
            end
            BE_SCALE: begin
                gx_reg <= gx_reg * $signed({{(G_W-SCALE_W){1'b0}}, scale_x});
                gy_reg <= gy_reg * $signed({{(G_W-SCALE_W){1'b0}}, scale_y});
            end
            BE_MAG: begin
                magx_reg <= gx_reg[G_W-1] ? G_W'(-gx_reg) : G_W'(gx_reg);
                magy_reg <= gy_reg[G_W-1] ? G_W'(-gy_reg) : G_W'(gy_reg);
            end
            BE_SQX: begin
                acc_reg <= V_W'(magx_reg * magx_reg) + one_sq;
            end
            BE_SUM: begin
                acc_reg   <= acc_reg + V_W'(magy_reg * magy_reg);
                rem_s_reg <= '0;
                root_reg  <= '0;
                cnt_reg   <= '0;
            end
            BE_ROOT: begin
                acc_reg <= acc_reg << 2;
                cnt_reg <= cnt_reg + 1'b1;
                if (s_cand >= s_trial) begin
                    rem_s_reg <= (ROOT_W+1)'(s_cand - s_trial);
                    root_reg  <= {root_reg[ROOT_W-2:0], 1'b1};
                end else begin
                    rem_s_reg <= (ROOT_W+1)'(s_cand);
                    root_reg  <= {root_reg[ROOT_W-2:0], 1'b0};
                end
                if (root_done) comp_reg <= 2'd0;
            end
            BE_DINIT: begin
                drem_reg  <= ROOT_W'(dmag >> 1);
                dbits_reg <= {dmag[0], {(Q-1){1'b0}}};
                q_reg     <= '0;
                cnt_reg   <= '0;
            end
            BE_DIV: begin
                dbits_reg <= dbits_reg << 1;
                cnt_reg   <= cnt_reg + 1'b1;
                if (d_cand >= {1'b0, root_reg}) begin
                    drem_reg <= ROOT_W'(d_cand - {1'b0, root_reg});
                    q_reg    <= {q_reg[Q-2:0], 1'b1};
                end else begin
                    drem_reg <= d_cand[ROOT_W-1:0];
                    q_reg    <= {q_reg[Q-2:0], 1'b0};
                end
            end
            BE_ENC: begin
                chan_reg[comp_reg] <= prod[NORMAL_FRAC_BITS+8 -: 8];
                comp_reg           <= comp_reg + 2'd1;
            end
            BE_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_r_reg    <= chan_reg[0];
            out_g_reg    <= chan_reg[1];
            out_b_reg    <= chan_reg[2];
            out_a_reg    <= alpha_reg;
            out_last_reg <= last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BE_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = {out_a_reg, out_b_reg, out_g_reg, out_r_reg};
    assign m_last  = out_last_reg;
endmodule

// File: hdl/height_to_normal_map_unit.sv
// Top level of the height to normal map unit: config registers, front end,
// job queue and back end. Depends on hnm_pkg, hnm_front, hnm_fifo, hnm_back.
//
//  channel   dir  handshake             payload
//  s_axis    in   tvalid/tready         tdata[7:0] height, tuser operation
//  m_axis    out  tvalid/tready         tdata red,green,blue,alpha; tlast
//  cfg       in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
// The front end takes a word, reads the line stores and then updates the window
// before it takes the next; the update waits while the queue of FIFO_DEPTH jobs
// that sits between it and the back end is full. The back end works one pixel at
// a time through the square root and the divider shared by the three components.
// Reset is synchronous, active low; the line stores are not cleared.
// A stalled result waits in the output register while the next job is worked.
`include "height_to_normal_map_unit_defines.svh"
module height_to_normal_map_unit #(
    parameter int MAX_WIDTH        = hnm_pkg::DEF_MAX_WIDTH,
    parameter int SCALE_FRAC_BITS  = hnm_pkg::DEF_SCALE_FRAC_BITS,
    parameter int NORMAL_FRAC_BITS = hnm_pkg::DEF_NORMAL_FRAC_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // [7:0] height
    input  logic                           s_axis_tuser,  // [0] operation
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [31:0]                    m_axis_tdata,  // red, green, blue, alpha
    output logic                           m_axis_tlast,  // last_pixel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hnm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [15:0]                    cfg_data
);
    import hnm_pkg::*;

    logic [IMG_W_W-1:0] image_width_reg;
    logic [IMG_H_W-1:0] image_height_reg;
    logic [SCALE_W-1:0] scale_x_reg, scale_y_reg;
    job_t               job_in, job_out;
    logic               fifo_push, fifo_pop, fifo_full, fifo_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= RST_IMAGE_WIDTH;
            image_height_reg <= RST_IMAGE_HEIGHT;
            scale_x_reg      <= RST_SCALE;
            scale_y_reg      <= RST_SCALE;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[IMG_W_W-1:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                CFG_SCALE_X:      scale_x_reg      <= cfg_data;
                CFG_SCALE_Y:      scale_y_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    hnm_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_axis_tvalid),
        .s_ready      (s_axis_tready),
        .s_op         (s_axis_tuser),
        .s_height     (s_axis_tdata),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .job_push     (fifo_push),
        .job          (job_in),
        .fifo_full    (fifo_full)
    );

    hnm_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (fifo_push),
        .din     (job_in),
        .full    (fifo_full),
        .pop     (fifo_pop),
        .dout    (job_out),
        .empty   (fifo_empty)
    );

    hnm_back #(
        .SCALE_FRAC_BITS  (SCALE_FRAC_BITS),
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .scale_x    (scale_x_reg),
        .scale_y    (scale_y_reg),
        .job        (job_out),
        .fifo_empty (fifo_empty),
        .job_pop    (fifo_pop),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_data     (m_axis_tdata),
        .m_last     (m_axis_tlast)
    );

    // z is never negative, so blue never drops below mid scale
    `HNM_ASSERT_IMPL(a_blue_half, aclk, aresetn, m_axis_tvalid, m_axis_tdata[23:16] >= 8'd127)
    `HNM_ASSERT_IMPL(a_no_push_full, aclk, aresetn, fifo_push, !fifo_full)
    `HNM_ASSERT_IMPL(a_no_pop_empty, aclk, aresetn, fifo_pop, !fifo_empty)
    `HNM_ASSERT_NEXT(a_busy_after_take, aclk, aresetn,
                     s_axis_tvalid && s_axis_tready && !s_axis_tuser, !s_axis_tready)
endmodule

// File: tb/height_to_normal_map_unit_tb.sv
// Testbench for the height to normal map unit: streams height frames through
// the block and checks every RGBA word against a local predictor. Needs hnm_pkg.
`timescale 1ns / 100ps
module height_to_normal_map_unit_tb;
    import hnm_pkg::*;

    localparam int LS_DEPTH = 2048;
    localparam int NFB      = 15;
    localparam int SFB      = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 8'd200;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
    } rgba_px_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    height_to_normal_map_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // predictor state
    logic [11:0] img_w = 12'd512;
    logic [15:0] img_h = 16'd512;
    logic [15:0] scl_x = 16'd256;
    logic [15:0] scl_y = 16'd256;
    logic [7:0]  ls_upper [LS_DEPTH];
    logic [7:0]  ls_lower [LS_DEPTH];
    logic [7:0]  win [3][3];
    int unsigned in_col = 0, in_row = 0, out_col = 0, out_row = 0;
    bit          frame_done = 0;

    rgba_px_t    px_expected [$];
    int          mismatches = 0;
    int          items_sent = 0;
    int          snd_idle = 0;
    int          rcv_idle = 0;

    initial begin
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                win[r][c] = '0;
    end

    function automatic int unsigned eff_w();
        if (img_w == 0) return 1;
        if (img_w > LS_DEPTH) return LS_DEPTH;
        return img_w;
    endfunction

    function automatic int unsigned eff_h();
        return (img_h == 0) ? 1 : img_h;
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic [7:0] channel_code(input longint g, input longint unsigned len);
        longint unsigned mag, q, biased;
        mag = (g < 0) ? longint'(-g) : longint'(g);
        q = (mag << NFB) / len;
        biased = (g < 0) ? (64'd1 << NFB) - q : (64'd1 << NFB) + q;
        return 8'((biased * 255) >> (NFB + 1));
    endfunction

    task automatic advance_pixel(input op_t op, input logic [7:0] h);
        int unsigned w, hh, c, row_pos, col_pos;
        logic [7:0] smp;
        bit l, rt, tp, bt, last;
        longint ctr, x0, x1, y0, y1, xy0, xy1, xy2, xy3, dx, dy, gx, gy, one;
        longint unsigned len;
        rgba_px_t px;
        w = eff_w();
        hh = eff_h();
        if (op == OP_DRAIN && in_row < hh) return;
        smp = (op == OP_DRAIN) ? 8'd0 : h;
        c = in_col % LS_DEPTH;
        for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = ls_upper[c];
        win[1][2] = ls_lower[c];
        win[2][2] = smp;
        ls_upper[c] = ls_lower[c];
        ls_lower[c] = smp;
        row_pos = in_row;
        col_pos = in_col;
        if (in_col + 1 >= w) begin
            in_col = 0;
            if (in_row < 16'hFFFF) in_row++;
        end else begin
            in_col++;
        end
        if (!(row_pos >= 2 || (row_pos == 1 && col_pos >= 1))) return;
        l = out_col > 0;
        rt = out_col + 1 < w;
        tp = out_row > 0;
        bt = out_row + 1 < hh;
        ctr = win[1][1];
        x0 = l ? win[1][0] : ctr;
        x1 = rt ? win[1][2] : ctr;
        y0 = tp ? win[0][1] : ctr;
        y1 = bt ? win[2][1] : ctr;
        xy0 = (l && tp) ? win[0][0] : ctr;
        xy1 = (rt && tp) ? win[0][2] : ctr;
        xy2 = (l && bt) ? win[2][0] : ctr;
        xy3 = (rt && bt) ? win[2][2] : ctr;
        dx = 2 * (x0 - x1) + (xy0 - xy1) + (xy2 - xy3);
        dy = 2 * (y0 - y1) + (xy0 - xy2) + (xy1 - xy3);
        gx = dx * longint'(scl_x);
        gy = dy * longint'(scl_y);
        one = 64'd1 << SFB;
        len = root_floor(gx * gx + gy * gy + one * one);
        last = (out_row + 1 >= hh) && (out_col + 1 >= w);
        px.red = channel_code(gx, len);
        px.green = channel_code(gy, len);
        px.blue = channel_code(one, len);
        px.alpha = win[1][1];
        px.last = last;
        px_expected.insert(px_expected.size(), px);
        if (last) begin
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
            frame_done = 1;
        end else if (out_col + 1 >= w) begin
            out_col = 0;
            if (out_row < 16'hFFFF) out_row++;
        end else begin
            out_col++;
        end
    endtask

    task automatic check_word();
        rgba_px_t e;
        if (px_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h last %b", m_axis_tdata, m_axis_tlast);
            return;
        end
        e = px_expected.pop_front();
        if (m_axis_tdata !== {e.alpha, e.blue, e.green, e.red} || m_axis_tlast !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
                $display("word mismatch: exp r%h g%h b%h a%h l%b, got %h l%b",
                         e.red, e.green, e.blue, e.alpha, e.last, m_axis_tdata, m_axis_tlast);
        end
    endtask

    // result side: sample pre-edge values, randomise ready
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) check_word();
            m_axis_tready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    task automatic send_word(input op_t op, input logic [7:0] h);
        while ($urandom_range(99) < snd_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= h;
        s_axis_tuser <= op;
        do @(posedge aclk); while (!s_axis_tready);
        advance_pixel(op, h);
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_IMAGE_WIDTH:  img_w = val[11:0];
            CFG_IMAGE_HEIGHT: img_h = val;
            CFG_SCALE_X:      scl_x = val;
            CFG_SCALE_Y:      scl_y = val;
            default: ;
        endcase
    endtask

    task automatic set_frame(input logic [15:0] w, input logic [15:0] h,
                             input logic [15:0] sx, input logic [15:0] sy);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_SCALE_X, sx);
        write_reg(CFG_SCALE_Y, sy);
    endtask

    // wait until every word is back, then let the back end run dry
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (px_expected.size() != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
    endtask

    // pat: 0 random, 1 all low, 2 all high, 3 checkerboard, 4 ramp
    task automatic run_frame(input int pat, input bit noise);
        int unsigned n, total;
        logic [7:0] v;
        frame_done = 0;
        total = eff_w() * eff_h();
        n = 0;
        while (!frame_done) begin
            if (n < total) begin
                if (noise && $urandom_range(15) == 0) send_word(OP_DRAIN, 8'($urandom));
                case (pat)
                    1: v = 8'd0;
                    2: v = 8'd255;
                    3: v = ((n ^ (n / eff_w())) & 1) ? 8'd255 : 8'd0;
                    4: v = 8'(n * 37);
                    default: v = 8'($urandom);
                endcase
                send_word(OP_PUSH, v);
                n++;
            end else begin
                // tail: pushes here count as drains
                send_word(($urandom_range(3) == 0) ? OP_PUSH : OP_DRAIN, 8'($urandom));
            end
        end
        settle();
    endtask

    task automatic test_small_frames();
        set_frame(3, 3, 16'd256, 16'd256);
        run_frame(3, 0);
        run_frame(2, 0);
        set_frame(3, 3, 16'hFFFF, 16'hFFFF);
        run_frame(3, 0);
        run_frame(1, 0);
        set_frame(4, 3, 16'd0, 16'hFFFF);
        run_frame(4, 1);
        set_frame(4, 4, 16'hFFFF, 16'd0);
        run_frame(3, 0);
    endtask

    task automatic test_degenerate_sizes();
        // zero width and height behave as one
        set_frame(0, 0, 16'd512, 16'd128);
        run_frame(0, 1);
        set_frame(1, 5, 16'd300, 16'd700);
        run_frame(4, 1);
        set_frame(5, 1, 16'd300, 16'd700);
        run_frame(4, 1);
        // write to a missing register must leave the size alone
        write_reg(CFG_UNUSED_IDX, 16'hFFFF);
        run_frame(0, 0);
    endtask

    task automatic test_wide_row();
        // two long rows of a ramp
        set_frame(16'd64, 2, 16'd256, 16'd256);
        run_frame(4, 0);
    endtask

    task automatic test_random_frames();
        int unsigned target;
        logic [15:0] sx, sy;
        for (int ph = 0; ph < 3; ph++) begin
            snd_idle = (ph == 0) ? 17 : (ph == 1) ? 54 : 0;
            rcv_idle = (ph == 0) ? 54 : (ph == 1) ? 17 : 0;
            target = items_sent + 130;
            while (items_sent < target) begin
                case ($urandom_range(3))
                    0: sx = 16'hFFFF;
                    1: sx = 16'd0;
                    default: sx = 16'($urandom);
                endcase
                sy = ($urandom_range(3) == 0) ? 16'd256 : 16'($urandom);
                set_frame($urandom_range(1, 12), $urandom_range(1, 6), sx, sy);
                run_frame($urandom_range(4) == 0 ? 3 : 0, 1);
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        snd_idle = 17;
        rcv_idle = 54;
        test_small_frames();
        test_degenerate_sizes();
        test_wide_row();
        test_random_frames();
        settle();
        if (mismatches == 0 && px_expected.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("Mismatches found");
        $finish;
    end
endmodule
